FILE: rtl/lbc_pkg.sv
// lbc_pkg: shared types, codes and constant tables for the layer blend combiner
// used by lbc_alu and layer_blend_combiner; no dependencies
package lbc_pkg;

  localparam int MAX_LAYERS = 8;
  localparam int LAYER_W    = 8;
  localparam int COUNT_W    = 4;
  localparam int MODE_W     = 3;
  localparam int CFG_DATA_W = 4;
  localparam int ACC_W      = 16;
  localparam int IDX_W      = $clog2(MAX_LAYERS);

  // register indexes on the configuration port
  localparam logic REG_BLEND_MODE  = 1'b0;
  localparam logic REG_LAYER_COUNT = 1'b1;

  typedef enum logic [MODE_W-1:0] {
    MODE_MEAN = 3'd0,
    MODE_MAX  = 3'd1,
    MODE_MIN  = 3'd2,
    MODE_MUL  = 3'd3,
    MODE_OVL  = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_STEP,
    S_DIV,
    S_OUT
  } state_t;

  typedef struct packed {
    mode_t              mode;
    logic               divide;
    logic [COUNT_W-1:0] count;
  } alu_ctl_t;

  // clamp the programmed count to 1..MAX_LAYERS
  function automatic logic [COUNT_W-1:0] eff_count(input logic [COUNT_W-1:0] lc);
    logic [COUNT_W-1:0] n;
    n = lc;
    if (n == '0) n = COUNT_W'(1);
    if (n > COUNT_W'(MAX_LAYERS)) n = COUNT_W'(MAX_LAYERS);
    return n;
  endfunction

  // unused mode codes fall back to the mean
  function automatic mode_t decode_mode(input logic [MODE_W-1:0] code);
    mode_t m;
    case (code)
      MODE_MAX: m = MODE_MAX;
      MODE_MIN: m = MODE_MIN;
      MODE_MUL: m = MODE_MUL;
      MODE_OVL: m = MODE_OVL;
      default:  m = MODE_MEAN;
    endcase
    return m;
  endfunction

  // ceil(2^16 / n): sum * recip >> 16 is the exact floor for sums below 2^11
  function automatic logic [16:0] recip(input logic [COUNT_W-1:0] n);
    logic [16:0] r;
    case (n)
      4'd2:    r = 17'd32768;
      4'd3:    r = 17'd21846;
      4'd4:    r = 17'd16384;
      4'd5:    r = 17'd13108;
      4'd6:    r = 17'd10923;
      4'd7:    r = 17'd9363;
      4'd8:    r = 17'd8192;
      default: r = 17'd65536;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/lbc_alu.sv
// lbc_alu: shared step unit, one multiplier plus add and compare
// depends on lbc_pkg
module lbc_alu (
  input  lbc_pkg::alu_ctl_t               ctl,
  input  logic [lbc_pkg::ACC_W-1:0]       acc,
  input  logic [lbc_pkg::LAYER_W-1:0]     v,
  output logic [lbc_pkg::ACC_W-1:0]       res
);

  logic [16:0] mul_x;
  logic [10:0] mul_y;
  logic [27:0] prod;
  logic [24:0] ovl_diff;
  logic        ovl_low;

  assign ovl_low  = (acc < 16'h8000);
  assign prod     = {11'b0, mul_x} * {17'b0, mul_y};
  assign ovl_diff = 25'h1000000 - {prod[23:0], 1'b0};

  always_comb begin
    mul_x = '0;
    mul_y = '0;
    res   = acc;
    if (ctl.divide) begin
      // mean: sum times reciprocal of the count, quotient stays below 2^11
      mul_x = lbc_pkg::recip(ctl.count);
      mul_y = acc[10:0];
      res   = {4'b0, prod[27:16]};
    end else begin
      case (ctl.mode)
        lbc_pkg::MODE_MAX: res = ({8'b0, v} > acc) ? {8'b0, v} : acc;
        lbc_pkg::MODE_MIN: res = ({8'b0, v} < acc) ? {8'b0, v} : acc;
        lbc_pkg::MODE_MUL: begin
          mul_x = {1'b0, acc};
          mul_y = {3'b0, v};
          res   = {8'b0, prod[15:8]};
        end
        lbc_pkg::MODE_OVL: begin
          if (ovl_low) begin
            mul_x = {1'b0, acc};
            mul_y = {3'b0, v};
            res   = prod[22:7];
          end else begin
            // screen half: 1 - 2(1-a)(1-v)
            mul_x = 17'h10000 - {1'b0, acc};
            mul_y = {2'b0, 9'h100 - {1'b0, v}};
            res   = ovl_diff[23:8];
          end
        end
        default: res = acc + {8'b0, v};
      endcase
    end
  end

endmodule

FILE: rtl/layer_blend_combiner.sv
// Layer blend combiner: folds up to eight 8-bit layer bytes into one byte by mean,
// maximum, minimum, normalized multiply or chained overlay. An item is taken when start
// is high and busy low; layers are walked one per cycle through a single shared
// multiply/add/compare unit, and after the last layer step (plus, for the mean, one
// reciprocal-multiply step) the result appears on blended_byte with done high for one
// cycle; the next item can be started in the cycle after done. The result must be
// taken in the done cycle. Configuration is written through cfg_we/cfg_index/cfg_data
// and should only change while busy is low.
// depends on lbc_pkg and lbc_alu
module layer_blend_combiner (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic                              cfg_index,
  input  logic [lbc_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              start,
  output logic                              busy,
  input  logic [lbc_pkg::LAYER_W-1:0]       layer_0,
  input  logic [lbc_pkg::LAYER_W-1:0]       layer_1,
  input  logic [lbc_pkg::LAYER_W-1:0]       layer_2,
  input  logic [lbc_pkg::LAYER_W-1:0]       layer_3,
  input  logic [lbc_pkg::LAYER_W-1:0]       layer_4,
  input  logic [lbc_pkg::LAYER_W-1:0]       layer_5,
  input  logic [lbc_pkg::LAYER_W-1:0]       layer_6,
  input  logic [lbc_pkg::LAYER_W-1:0]       layer_7,
  output logic                              done,
  output logic [lbc_pkg::LAYER_W-1:0]       blended_byte
);

  logic [lbc_pkg::MODE_W-1:0]  blend_mode;
  logic [lbc_pkg::COUNT_W-1:0] layer_count;

  lbc_pkg::state_t             state, state_next;
  lbc_pkg::alu_ctl_t           ctl;
  logic [lbc_pkg::LAYER_W-1:0] layers [lbc_pkg::MAX_LAYERS];
  logic [lbc_pkg::ACC_W-1:0]   acc;
  logic [lbc_pkg::ACC_W-1:0]   alu_res;
  logic [lbc_pkg::IDX_W-1:0]   idx;
  logic [lbc_pkg::COUNT_W-1:0] count_in;
  lbc_pkg::mode_t              mode_in;
  logic                        accept;
  logic                        last_step;

  assign accept    = start && !busy;
  assign count_in  = lbc_pkg::eff_count(layer_count);
  assign mode_in   = lbc_pkg::decode_mode(blend_mode);
  assign last_step = ({1'b0, idx} == ctl.count - lbc_pkg::COUNT_W'(1));

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      blend_mode  <= lbc_pkg::MODE_MEAN;
      layer_count <= 4'd2;
    end else if (cfg_we) begin
      if (cfg_index == lbc_pkg::REG_BLEND_MODE) begin
        blend_mode <= cfg_data[lbc_pkg::MODE_W-1:0];
      end else begin
        layer_count <= cfg_data;
      end
    end
  end

  lbc_alu u_alu (
    .ctl (ctl),
    .acc (acc),
    .v   (layers[idx]),
    .res (alu_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lbc_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      lbc_pkg::S_IDLE: begin
        if (accept) begin
          if (count_in != lbc_pkg::COUNT_W'(1)) begin
            state_next = lbc_pkg::S_STEP;
          end else if (mode_in == lbc_pkg::MODE_MEAN) begin
            state_next = lbc_pkg::S_DIV;
          end else begin
            state_next = lbc_pkg::S_OUT;
          end
        end
      end
      lbc_pkg::S_STEP: begin
        if (last_step) begin
          state_next = (ctl.mode == lbc_pkg::MODE_MEAN) ? lbc_pkg::S_DIV : lbc_pkg::S_OUT;
        end
      end
      lbc_pkg::S_DIV: state_next = lbc_pkg::S_OUT;
      lbc_pkg::S_OUT: state_next = lbc_pkg::S_IDLE;
      default:        state_next = lbc_pkg::S_IDLE;
    endcase
  end

  // item capture and accumulator walk
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl <= '{mode: lbc_pkg::MODE_MEAN, divide: 1'b0, count: lbc_pkg::COUNT_W'(1)};
      idx <= '0;
    end else if (accept) begin
      ctl.mode   <= mode_in;
      ctl.count  <= count_in;
      ctl.divide <= (count_in == lbc_pkg::COUNT_W'(1)) && (mode_in == lbc_pkg::MODE_MEAN);
      idx        <= lbc_pkg::IDX_W'(1);
    end else if (state == lbc_pkg::S_STEP) begin
      idx        <= idx + lbc_pkg::IDX_W'(1);
      ctl.divide <= last_step && (ctl.mode == lbc_pkg::MODE_MEAN);
    end else if (state == lbc_pkg::S_DIV) begin
      ctl.divide <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      layers[0] <= layer_0;
      layers[1] <= layer_1;
      layers[2] <= layer_2;
      layers[3] <= layer_3;
      layers[4] <= layer_4;
      layers[5] <= layer_5;
      layers[6] <= layer_6;
      layers[7] <= layer_7;
      // overlay holds the value as a 16-bit fraction
      acc <= (mode_in == lbc_pkg::MODE_OVL) ? {layer_0, 8'b0} : {8'b0, layer_0};
    end else if (state == lbc_pkg::S_STEP || state == lbc_pkg::S_DIV) begin
      acc <= alu_res;
    end
  end

  assign busy         = (state != lbc_pkg::S_IDLE);
  assign done         = (state == lbc_pkg::S_OUT);
  assign blended_byte = (ctl.mode == lbc_pkg::MODE_OVL) ? acc[15:8] : acc[7:0];

endmodule

FILE: rtl/lbc_checker.sv
// lbc_checker: port-level checks of the layer blend combiner handshake and sequencing
// depends on lbc_pkg; bound to layer_blend_combiner
module lbc_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          start,
  input logic                          busy,
  input logic                          done,
  input logic [lbc_pkg::LAYER_W-1:0]   blended_byte
);

  // a result only shows while an item is in flight
  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("done without busy");

  // an accepted item makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  // one result per item, then back to idle
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> (!done && !busy))
    else $error("done held or block stayed busy after result");

  // busy only starts from an accepted item
  a_busy_rise: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start))
    else $error("busy rose without start");

  // result byte is known when shown
  a_byte_known: assert property (@(posedge clk) disable iff (rst)
    done |-> !$isunknown(blended_byte))
    else $error("unknown result byte");

endmodule

bind layer_blend_combiner lbc_checker u_lbc_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .done         (done),
  .blended_byte (blended_byte)
);
